/* hw/rtl/ctp_pkg.sv */
// shared types and constants of the configurable twister generator
package ctp_pkg;

  localparam int unsigned BLOCK_W    = 128;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // seeding recurrence multiplier
  localparam logic [WORD_W-1:0] SEED_MULT = 32'd1812433253;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE_TAP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_SHL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SHL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_SHR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SHR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_LOW    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_HIGH   = 3'd6;

  typedef enum logic [1:0] {
    OP_SEED    = 2'd0,
    OP_DRAW32  = 2'd1,
    OP_DRAW64  = 2'd2,
    OP_DRAW128 = 2'd3
  } ctp_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_DELIVER,
    ST_REC_C,
    ST_REC_D,
    ST_REC_W
  } ctp_state_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] seed_value;
  } ctp_req_t;

  typedef struct packed {
    logic [63:0] value_low;
    logic [63:0] value_high;
    logic        misaligned;
  } ctp_rsp_t;

  typedef struct packed {
    logic [4:0]         word_left_shift;
    logic [2:0]         block_byte_left_shift;
    logic [4:0]         word_right_shift;
    logic [2:0]         block_byte_right_shift;
    logic [BLOCK_W-1:0] mask;
  } ctp_recur_cfg_t;

  typedef struct packed {
    logic busy;
    logic wr_en;
  } ctp_seed_st_t;

endpackage

/* hw/rtl/ctp_stream_if.sv */
// valid/ready stream channel carrying one payload type
interface ctp_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/ctp_recur.sv */
// block recursion datapath: combines the four blocks into the new block
module ctp_recur (
  input  ctp_pkg::ctp_recur_cfg_t cfg_i,
  input  logic [127:0]            a_i,
  input  logic [127:0]            b_i,
  input  logic [127:0]            c_i,
  input  logic [127:0]            d_i,
  output logic [127:0]            blk_o
);
  import ctp_pkg::*;

  logic [BLOCK_W-1:0] a_shl;
  logic [BLOCK_W-1:0] c_shr;

  // whole-block byte shifts
  assign a_shl = a_i << {cfg_i.block_byte_left_shift, 3'b000};
  assign c_shr = c_i >> {cfg_i.block_byte_right_shift, 3'b000};

  // per-word terms and xor
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      blk_o[WORD_W*k +: WORD_W] = a_i[WORD_W*k +: WORD_W]
        ^ a_shl[WORD_W*k +: WORD_W]
        ^ ((b_i[WORD_W*k +: WORD_W] >> cfg_i.word_right_shift)
           & cfg_i.mask[WORD_W*k +: WORD_W])
        ^ c_shr[WORD_W*k +: WORD_W]
        ^ (d_i[WORD_W*k +: WORD_W] << cfg_i.word_left_shift);
    end
  end

endmodule

/* hw/rtl/ctp_seed.sv */
// seeding sequencer: one multiply step per cycle, one block write per four words
module ctp_seed #(
  parameter int unsigned BLOCKS = 156
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [31:0]                seed_i,
  output ctp_pkg::ctp_seed_st_t      status_o,
  output logic [$clog2(BLOCKS)-1:0]  wr_addr_o,
  output logic [127:0]               wr_data_o
);
  import ctp_pkg::*;

  localparam int unsigned BW = $clog2(BLOCKS);
  localparam int unsigned PW = BW + 2;
  localparam logic [PW-1:0] LAST_IDX = PW'(4 * BLOCKS - 1);

  logic              active_q;
  logic [PW-1:0]     idx_q;
  logic [WORD_W-1:0] prev_q;
  logic [WORD_W-1:0] mixed;
  logic [WORD_W-1:0] prev_d;
  logic [95:0]       row_q;

  // next word of the linear recurrence
  assign mixed  = prev_q ^ (prev_q >> 30);
  assign prev_d = 32'(SEED_MULT * mixed) + 32'(idx_q) + 32'd1;

  // word counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
    end else if (start_i) begin
      active_q <= 1'b1;
      idx_q    <= '0;
    end else if (active_q) begin
      idx_q <= idx_q + PW'(1);
      if (idx_q == LAST_IDX) begin
        active_q <= 1'b0;
      end
    end
  end

  // word chain and row assembly
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prev_q <= seed_i;
    end else if (active_q) begin
      prev_q <= prev_d;
      if (idx_q[1:0] != 2'd3) begin
        row_q[WORD_W*idx_q[1:0] +: WORD_W] <= prev_q;
      end
    end
  end

  assign status_o.busy  = active_q;
  assign status_o.wr_en = active_q && (idx_q[1:0] == 2'd3);
  assign wr_addr_o      = idx_q[PW-1:2];
  assign wr_data_o      = {prev_q, row_q};

endmodule

/* hw/rtl/configurable_twister_prng.sv */
// top level of the configurable twister generator
//
// The generator keeps BLOCKS blocks of 128 bits in one synchronous memory with
// one read and one write port, and a word read position. A seed transaction
// fills the ring at one 32-bit word per cycle; no draw is taken meanwhile.
// A draw reads the memory at the accepting edge, and the result register loads
// in the deliver state once the output register is free. A draw that finishes
// a block, and every 128-bit draw, then reads the middle, second-last and last
// blocks through the read port in turn and writes the new block back. A 64-bit
// draw at an odd position returns misaligned from the deliver state and changes
// nothing. A finished result waits in an output register while the next
// transaction is accepted. Draws before the first seed return undefined data.
module configurable_twister_prng #(
  parameter int unsigned BLOCKS = 156
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ctp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ctp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  ctp_stream_if.sink                       req_i,
  ctp_stream_if.source                     rsp_o
);
  import ctp_pkg::*;

  localparam int unsigned BW = $clog2(BLOCKS);
  localparam int unsigned PW = BW + 2;
  localparam logic [PW:0]   POS_END = (PW + 1)'(4 * BLOCKS);
  localparam logic [BW:0]   BLK_END = (BW + 1)'(BLOCKS);
  localparam logic [BW-1:0] BACK2   = BW'(BLOCKS - 2);
  localparam logic [BW-1:0] BACK1   = BW'(BLOCKS - 1);

  ctp_state_e state_q, state_d;

  // configuration registers
  logic [7:0]  middle_tap_q;
  logic [4:0]  word_shl_q;
  logic [2:0]  block_shl_q;
  logic [4:0]  word_shr_q;
  logic [2:0]  block_shr_q;
  logic [63:0] mask_low_q;
  logic [63:0] mask_high_q;
  ctp_recur_cfg_t recur_cfg;

  logic [15:0]   tap_rem;
  logic [BW-1:0] tap_mod_q;

  // transaction context
  logic [PW-1:0]  pos_q;
  logic [PW:0]    pos_next;
  logic [BW-1:0]  cur_blk;
  logic [1:0]     cur_sub;
  ctp_op_e        op_q;
  logic           mis_q;
  logic [BW-1:0]  blk_q;
  logic [127:0]   a_q;
  logic [127:0]   b_q;
  logic [127:0]   c_q;
  logic           rec_need;
  logic           req_fire;

  // ring addresses
  logic [BW:0]    b_sum;
  logic [BW-1:0]  b_idx;
  logic [BW-1:0]  c_idx;
  logic [BW-1:0]  d_idx;

  // ring memory
  logic [127:0]   ring_mem [BLOCKS];
  logic           rd_en;
  logic [BW-1:0]  rd_addr;
  logic [127:0]   rd_data_q;
  logic           wr_en;
  logic [BW-1:0]  wr_addr;
  logic [127:0]   wr_data;
  logic [127:0]   rec_data;

  // seeding
  logic           seed_start;
  ctp_seed_st_t   seed_st;
  logic [BW-1:0]  seed_addr;
  logic [127:0]   seed_data;

  // result register
  logic           out_valid_q;
  ctp_rsp_t       out_q;
  ctp_rsp_t       rsp_d;
  logic           slot_free;
  logic           out_load;

  assign req_i.ready   = (state_q == ST_IDLE);
  assign req_fire      = req_i.valid && req_i.ready;
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;
  assign slot_free     = !out_valid_q || rsp_o.ready;

  assign cur_blk = pos_q[PW-1:2];
  assign cur_sub = pos_q[1:0];

  assign recur_cfg.word_left_shift        = word_shl_q;
  assign recur_cfg.block_byte_left_shift  = block_shl_q;
  assign recur_cfg.word_right_shift       = word_shr_q;
  assign recur_cfg.block_byte_right_shift = block_shr_q;
  assign recur_cfg.mask                   = {mask_high_q, mask_low_q};

  // middle tap modulo ring size by restoring reduction
  always_comb begin
    tap_rem = {8'b0, middle_tap_q};
    for (int k = 5; k >= 0; k--) begin
      if (tap_rem >= 16'(BLOCKS << k)) begin
        tap_rem = tap_rem - 16'(BLOCKS << k);
      end
    end
  end

  // neighbor block addresses with ring wrap
  assign b_sum = {1'b0, cur_blk} + {1'b0, tap_mod_q};
  assign b_idx = (b_sum >= BLK_END) ? BW'(b_sum - BLK_END) : b_sum[BW-1:0];
  assign c_idx = (blk_q < BW'(2)) ? blk_q + BACK2 : blk_q - BW'(2);
  assign d_idx = (blk_q < BW'(1)) ? blk_q + BACK1 : blk_q - BW'(1);

  // does this draw finish its block
  assign rec_need = ((op_q == OP_DRAW32) && (cur_sub == 2'd3))
                 || ((op_q == OP_DRAW64) && (cur_sub == 2'd2))
                 || (op_q == OP_DRAW128);

  // position after the draw
  always_comb begin
    case (op_q)
      OP_DRAW32:  pos_next = {1'b0, pos_q} + (PW + 1)'(1);
      OP_DRAW64:  pos_next = {1'b0, pos_q} + (PW + 1)'(2);
      OP_DRAW128: pos_next = {1'b0, cur_blk, 2'b00} + (PW + 1)'(4);
      default:    pos_next = {1'b0, pos_q};
    endcase
    if (pos_next >= POS_END) begin
      pos_next = '0;
    end
  end

  // result formatting
  always_comb begin
    rsp_d = '0;
    if (mis_q) begin
      rsp_d.misaligned = 1'b1;
    end else begin
      case (op_q)
        OP_DRAW32:  rsp_d.value_low = {32'b0, rd_data_q[WORD_W*cur_sub +: WORD_W]};
        OP_DRAW64:  rsp_d.value_low = rd_data_q[64*cur_sub[1] +: 64];
        OP_DRAW128: begin
          rsp_d.value_low  = rd_data_q[63:0];
          rsp_d.value_high = rd_data_q[127:64];
        end
        default:    rsp_d = '0;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          state_d = (req_i.payload.opcode == OP_SEED) ? ST_SEED : ST_DELIVER;
        end
      end
      ST_SEED: begin
        if (!seed_st.busy) begin
          state_d = ST_IDLE;
        end
      end
      ST_DELIVER: begin
        if (slot_free) begin
          state_d = (!mis_q && rec_need) ? ST_REC_C : ST_IDLE;
        end
      end
      ST_REC_C: state_d = ST_REC_D;
      ST_REC_D: state_d = ST_REC_W;
      ST_REC_W: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // state outputs: memory port, seeding start, result load
  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = cur_blk;
    wr_en      = 1'b0;
    wr_addr    = seed_addr;
    wr_data    = seed_data;
    seed_start = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        rd_en      = req_fire && (req_i.payload.opcode != OP_SEED);
        seed_start = req_fire && (req_i.payload.opcode == OP_SEED);
      end
      ST_SEED: begin
        wr_en = seed_st.wr_en;
      end
      ST_DELIVER: begin
        out_load = slot_free;
        if (slot_free && !mis_q && rec_need) begin
          rd_en   = 1'b1;
          rd_addr = b_idx;
        end
      end
      ST_REC_C: begin
        rd_en   = 1'b1;
        rd_addr = c_idx;
      end
      ST_REC_D: begin
        rd_en   = 1'b1;
        rd_addr = d_idx;
      end
      ST_REC_W: begin
        wr_en   = 1'b1;
        wr_addr = blk_q;
        wr_data = rec_data;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // control registers and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pos_q        <= '0;
      out_valid_q  <= 1'b0;
      middle_tap_q <= 8'd1;
      word_shl_q   <= 5'd11;
      block_shl_q  <= 3'd1;
      word_shr_q   <= 5'd7;
      block_shr_q  <= 3'd1;
      mask_low_q   <= 64'h0000_0007_0000_0007;
      mask_high_q  <= 64'h0000_0007_0000_0007;
    end else begin
      state_q <= state_d;
      if (seed_start) begin
        pos_q <= '0;
      end else if (out_load && !mis_q) begin
        pos_q <= pos_next[PW-1:0];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIDDLE_TAP: middle_tap_q <= cfg_data_i[7:0];
          CFG_WORD_SHL:   word_shl_q   <= cfg_data_i[4:0];
          CFG_BLOCK_SHL:  block_shl_q  <= cfg_data_i[2:0];
          CFG_WORD_SHR:   word_shr_q   <= cfg_data_i[4:0];
          CFG_BLOCK_SHR:  block_shr_q  <= cfg_data_i[2:0];
          CFG_MASK_LOW:   mask_low_q   <= cfg_data_i;
          CFG_MASK_HIGH:  mask_high_q  <= cfg_data_i;
          default:        middle_tap_q <= middle_tap_q;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    tap_mod_q <= tap_rem[BW-1:0];
    if (req_fire) begin
      op_q  <= ctp_op_e'(req_i.payload.opcode);
      mis_q <= (req_i.payload.opcode == OP_DRAW64) && pos_q[0];
    end
    if (out_load) begin
      out_q <= rsp_d;
      blk_q <= cur_blk;
      a_q   <= rd_data_q;
    end
    if (state_q == ST_REC_C) begin
      b_q <= rd_data_q;
    end
    if (state_q == ST_REC_D) begin
      c_q <= rd_data_q;
    end
  end

  // block ring memory, one read and one write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= ring_mem[rd_addr];
    end
  end

  ctp_seed #(
    .BLOCKS (BLOCKS)
  ) u_seed (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (seed_start),
    .seed_i    (req_i.payload.seed_value),
    .status_o  (seed_st),
    .wr_addr_o (seed_addr),
    .wr_data_o (seed_data)
  );

  // last block arrives straight from the memory read register
  ctp_recur u_recur (
    .cfg_i (recur_cfg),
    .a_i   (a_q),
    .b_i   (b_q),
    .c_i   (c_q),
    .d_i   (rd_data_q),
    .blk_o (rec_data)
  );

`ifndef SYNTHESIS
  // position stays inside the ring
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_q} < POS_END)
    else $error("word position out of range");

  // seeding runs only while the sequencer waits for it
  a_seed_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seed_st.busy |-> (state_q == ST_SEED))
    else $error("seeding active outside seed state");

  // a misaligned draw leaves the position alone
  a_mis_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DELIVER && mis_q && slot_free) |=> $stable(pos_q))
    else $error("misaligned draw moved the position");

  // write-back follows a delivered draw and three reads
  a_rec_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REC_W) |-> ($past(state_q, 3) == ST_DELIVER))
    else $error("block write-back out of sequence");
`endif

endmodule

/* tb/sv/testbench.sv */
// self-checking testbench for the configurable twister generator
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ctp_pkg::*;

  localparam int unsigned RING_BLOCKS  = 156;
  localparam int unsigned RING_WORDS   = 4 * RING_BLOCKS;
  // a seed fills the whole ring one word per cycle, so allow that before any write
  localparam int unsigned DRAIN_CYCLES = 4 * RING_BLOCKS + 8;
  localparam int unsigned CYCLE_LIMIT  = 500_000;
  localparam int unsigned RANDOM_ITEMS = 200;
  localparam int unsigned HOLD_AT      = 950;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned MAX_REPORTS  = 10;
  // index past the register list, writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ctp_stream_if #(.payload_t(ctp_req_t)) req_if ();
  ctp_stream_if #(.payload_t(ctp_rsp_t)) rsp_if ();

  configurable_twister_prng #(
    .BLOCKS (RING_BLOCKS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // predicted generator state and register copies
  logic [BLOCK_W-1:0] twist_ring [RING_BLOCKS];
  int unsigned        read_pos;
  logic [7:0]         tap_dist;
  logic [4:0]         shl_word;
  logic [2:0]         shl_bytes;
  logic [4:0]         shr_word;
  logic [2:0]         shr_bytes;
  logic [63:0]        mask_lo;
  logic [63:0]        mask_hi;

  ctp_req_t pending_requests [$];
  ctp_rsp_t expected_draws [$];
  ctp_rsp_t want_rsp;
  ctp_rsp_t got_rsp;

  int unsigned queued_total;
  int unsigned accepted_total;
  int unsigned checked_results;
  int unsigned misaligned_draws;
  int unsigned seeds_sent;
  int unsigned ring_wraps;
  int unsigned config_sets;
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_left;
  logic        hold_done;

  // seeding recurrence over every word of the ring
  function automatic void fill_ring(input logic [31:0] seed);
    logic [31:0] prev;
    prev = seed;
    twist_ring[0][31:0] = seed;
    for (int unsigned i = 1; i < RING_WORDS; i++) begin
      prev = SEED_MULT * (prev ^ (prev >> 30)) + i;
      twist_ring[i / 4][32 * (i % 4) +: 32] = prev;
    end
    read_pos = 0;
  endfunction

  // replace one block in place by the recursion
  function automatic void twist_block(input int unsigned blk);
    logic [BLOCK_W-1:0] cur;
    logic [BLOCK_W-1:0] mid;
    logic [BLOCK_W-1:0] back2;
    logic [BLOCK_W-1:0] back1;
    logic [BLOCK_W-1:0] masks;
    logic [BLOCK_W-1:0] nxt;
    cur   = twist_ring[blk];
    mid   = twist_ring[(blk + tap_dist % RING_BLOCKS) % RING_BLOCKS];
    back2 = twist_ring[(blk + RING_BLOCKS - 2) % RING_BLOCKS];
    back1 = twist_ring[(blk + RING_BLOCKS - 1) % RING_BLOCKS];
    masks = {mask_hi, mask_lo};
    // byte shifts act on the whole block, bit shifts and masks per word
    nxt = cur ^ (cur << (8 * shl_bytes)) ^ (back2 >> (8 * shr_bytes));
    for (int k = 0; k < 4; k++) begin
      nxt[32 * k +: 32] ^= ((mid[32 * k +: 32] >> shr_word) & masks[32 * k +: 32])
                           ^ (back1[32 * k +: 32] << shl_word);
    end
    twist_ring[blk] = nxt;
  endfunction

  // advance the predicted state by one request, queueing the draw it returns
  function automatic void draw_expected(input ctp_req_t req);
    ctp_rsp_t    rsp;
    int unsigned pos;
    int unsigned blk;
    int unsigned sub;
    if (req.opcode == OP_SEED) begin
      fill_ring(req.seed_value);
      seeds_sent++;
      return;
    end
    rsp = '0;
    pos = read_pos % RING_WORDS;
    blk = pos / 4;
    sub = pos % 4;
    case (req.opcode)
      OP_DRAW32: begin
        rsp.value_low = {32'd0, twist_ring[blk][32 * sub +: 32]};
        if (sub == 3) twist_block(blk);
        pos = pos + 1;
      end
      OP_DRAW64: begin
        // odd position: flag only, state untouched
        if (sub % 2 == 1) begin
          rsp.misaligned = 1'b1;
          misaligned_draws++;
          expected_draws.push_back(rsp);
          return;
        end
        rsp.value_low = twist_ring[blk][32 * sub +: 64];
        if (sub == 2) twist_block(blk);
        pos = pos + 2;
      end
      OP_DRAW128: begin
        // whole block holding the current word, then skip to the next block
        rsp.value_low  = twist_ring[blk][63:0];
        rsp.value_high = twist_ring[blk][127:64];
        twist_block(blk);
        pos = (blk + 1) * 4;
      end
      default: ;
    endcase
    if (pos >= RING_WORDS) begin
      pos = 0;
      ring_wraps++;
    end
    read_pos = pos;
    expected_draws.push_back(rsp);
  endfunction

  function automatic void flag_mismatch(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("mismatch in %s at result %0d: expected %h, got %h",
               what, checked_results, want, got);
    end
  endfunction

  function automatic void push_req(input ctp_op_e op, input logic [31:0] seed);
    ctp_req_t item;
    item.opcode     = op;
    item.seed_value = seed;
    pending_requests.push_back(item);
    queued_total++;
  endfunction

  // mostly draws with a rare reseed, so the position wraps the ring several times
  function automatic void push_random_req();
    int unsigned roll;
    roll = $urandom_range(999);
    if (roll < 6) begin
      push_req(OP_SEED, $urandom());
    end else if (roll < 330) begin
      push_req(OP_DRAW32, $urandom());
    end else if (roll < 640) begin
      push_req(OP_DRAW64, $urandom());
    end else begin
      push_req(OP_DRAW128, $urandom());
    end
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // request driver: prediction happens at each accepted transaction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        draw_expected(req_if.payload);
        accepted_total++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_if.valid   <= 1'b1;
          req_if.payload <= pending_requests.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off so the result register fills and backs up the input
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_total >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor: compare each transaction with the oldest prediction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got_rsp = rsp_if.payload;
        if (expected_draws.size() == 0) begin
          flag_mismatch("unexpected result", 64'd0, got_rsp.value_low);
        end else begin
          want_rsp = expected_draws.pop_front();
          if (got_rsp.value_low !== want_rsp.value_low)
            flag_mismatch("value_low", want_rsp.value_low, got_rsp.value_low);
          if (got_rsp.value_high !== want_rsp.value_high)
            flag_mismatch("value_high", want_rsp.value_high, got_rsp.value_high);
          if (got_rsp.misaligned !== want_rsp.misaligned)
            flag_mismatch("misaligned", 64'(want_rsp.misaligned), 64'(got_rsp.misaligned));
        end
        checked_results++;
      end
      rsp_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic wait_drained();
    do @(negedge clk_i);
    while (accepted_total != queued_total || expected_draws.size() != 0);
  endtask

  // drain, then give a trailing seed time to finish before going on
  task automatic settle();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_MIDDLE_TAP: tap_dist  = data[7:0];
      CFG_WORD_SHL:   shl_word  = data[4:0];
      CFG_BLOCK_SHL:  shl_bytes = data[2:0];
      CFG_WORD_SHR:   shr_word  = data[4:0];
      CFG_BLOCK_SHR:  shr_bytes = data[2:0];
      CFG_MASK_LOW:   mask_lo   = data;
      CFG_MASK_HIGH:  mask_hi   = data;
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [63:0] tap, input logic [63:0] wshl,
                              input logic [63:0] bshl, input logic [63:0] wshr,
                              input logic [63:0] bshr, input logic [63:0] mlo,
                              input logic [63:0] mhi);
    settle();
    write_reg(CFG_MIDDLE_TAP, tap);
    write_reg(CFG_WORD_SHL, wshl);
    write_reg(CFG_BLOCK_SHL, bshl);
    write_reg(CFG_WORD_SHR, wshr);
    write_reg(CFG_BLOCK_SHR, bshr);
    write_reg(CFG_MASK_LOW, mlo);
    write_reg(CFG_MASK_HIGH, mhi);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    config_sets++;
  endtask

  task automatic random_config();
    apply_config({$urandom(), $urandom()}, {$urandom(), $urandom()},
                 {$urandom(), $urandom()}, {$urandom(), $urandom()},
                 {$urandom(), $urandom()}, {$urandom(), $urandom()},
                 {$urandom(), $urandom()});
  endtask

  task automatic run_random(input int unsigned s_idle, input int unsigned r_idle);
    @(negedge clk_i);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    repeat (RANDOM_ITEMS) push_random_req();
    wait_drained();
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b0;
    read_pos       = 0;
    tap_dist       = 8'd1;
    shl_word       = 5'd11;
    shl_bytes      = 3'd1;
    shr_word       = 5'd7;
    shr_bytes      = 3'd1;
    mask_lo        = 64'h0000_0007_0000_0007;
    mask_hi        = 64'h0000_0007_0000_0007;
    send_idle_pct  = 10;
    recv_idle_pct  = 80;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed sequence at reset settings, always seeding before the first draw
    @(negedge clk_i);
    push_req(OP_SEED, 32'h0000_0000);
    push_req(OP_DRAW32, $urandom());
    push_req(OP_DRAW64, $urandom());   // odd position
    push_req(OP_DRAW32, $urandom());
    push_req(OP_DRAW64, $urandom());   // ends block 0, wraps back for its neighbors
    push_req(OP_DRAW128, $urandom());
    push_req(OP_DRAW32, $urandom());
    push_req(OP_DRAW32, $urandom());
    push_req(OP_DRAW32, $urandom());
    push_req(OP_DRAW32, $urandom());   // last word of a block
    push_req(OP_DRAW32, $urandom());
    push_req(OP_DRAW128, $urandom());  // unaligned block draw
    push_req(OP_DRAW64, $urandom());
    push_req(OP_DRAW64, $urandom());
    push_req(OP_SEED, 32'hffff_ffff);
    push_req(OP_DRAW128, $urandom());
    push_req(OP_DRAW64, $urandom());
    push_req(OP_DRAW32, $urandom());
    push_req(OP_DRAW64, $urandom());   // odd position
    push_req(OP_DRAW32, $urandom());
    push_req(OP_SEED, 32'h8000_0001);
    push_req(OP_DRAW128, $urandom());
    push_req(OP_DRAW128, $urandom());
    wait_drained();

    // sender mostly busy, receiver mostly idle
    apply_config(64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0);
    write_reg(CFG_NO_REG, {$urandom(), $urandom()});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    run_random(10, 80);
    random_config();
    run_random(10, 80);

    // roles swapped
    apply_config(64'd255, 64'd31, 64'd7, 64'd31, 64'd7, '1, '1);
    run_random(80, 10);
    random_config();
    run_random(80, 10);

    // no idling, long receiver hold-off lands in here
    apply_config(64'd153, 64'd1, 64'd1, 64'd1, 64'd1,
                 {$urandom(), $urandom()}, {$urandom(), $urandom()});
    run_random(0, 0);
    random_config();
    run_random(0, 0);

    settle();
    @(negedge clk_i);
    $display("%0d results checked, %0d of them misaligned 64-bit draws, %0d seeds",
             checked_results, misaligned_draws, seeds_sent);
    $display("%0d register settings, read position wrapped the ring %0d times",
             config_sets, ring_wraps);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
